### rtl/core/rbsd_pkg.sv
// Package for the rolling-ball surface dilation block.
// Holds payload structs, command/status/register codes and sequencer states.
// No dependencies.
package rbsd_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int MAX_REACH_DEF   = 512;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_BUILT = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;

  localparam logic [1:0] REG_SAMPLE_COUNT   = 2'd0;
  localparam logic [1:0] REG_BALL_RADIUS    = 2'd1;
  localparam logic [1:0] REG_SAMPLE_SPACING = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [9:0]         index;
    logic signed [31:0] height;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] curve_height;
    logic [9:0]         reach;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_B_LIM,
    ST_B_RSQ,
    ST_B_DSQ,
    ST_B_SQI,
    ST_B_SQRT,
    ST_B_DEN,
    ST_B_WR,
    ST_Q_RD,
    ST_Q_EV,
    ST_OUT
  } state_t;

endpackage

### rtl/core/rbsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/rolling_ball_surface_dilation.sv
// Top level of the rolling-ball surface dilation block: sequencer, shared
// divider, square root, multiplier. Depends on rbsd_pkg and rbsd_ram.
//
// Channel   Direction  Handshake          Content
// in        request    in_valid/in_stall  in_item (cmd, index, height)
// out       result     out_valid/out_stall out_item (curve_height, reach, status)
// cfg       write      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Write and unused commands pass from idle straight to the output state and wait
// there while out_stall is high. A query walks 2*reach+1 neighbours, reading and
// then evaluating each in turn, as set by the one registered read port per memory.
// A build runs, per table entry, a 32-step square root and a 64-step shift-subtract divide on one shared datapath.
// Reset (rst, synchronous) clears control state; memories are not cleared.
// The block takes one request at a time; in_stall is high until the result
// has been taken.
module rolling_ball_surface_dilation
  #(
  parameter int MAX_SAMPLES = rbsd_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_REACH   = rbsd_pkg::MAX_REACH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rbsd_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rbsd_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  import rbsd_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int NW  = $clog2(MAX_SAMPLES + 1);
  localparam int CW  = (NW > 11) ? NW : 11;
  localparam int RW  = $clog2(MAX_REACH + 1);

  // Configuration and status registers
  logic [10:0]   count_reg;
  logic [31:0]   ball_radius;
  logic [31:0]   sample_spacing;
  logic          table_ready;
  logic [RW-1:0] reach_reg;

  state_t state, state_next;

  // Datapath registers
  logic [63:0]       div_q;
  logic [33:0]       div_r;
  logic [32:0]       div_d;
  logic              div_sag;
  logic [5:0]        step_cnt;
  logic [63:0]       sq_v;
  logic [63:0]       sq_r;
  logic [63:0]       sq_b;
  logic [63:0]       prod;
  logic [63:0]       r2;
  logic [31:0]       d_val;
  logic [RW-1:0]     k;
  logic [RW-1:0]     lim;
  logic [NW-1:0]     nb;
  logic [RW-1:0]     mag;
  logic              neg;
  logic              first;
  logic signed [33:0] best;
  logic signed [31:0] curve;
  logic [1:0]        status;

  // Effective sample count and request decode
  logic [CW-1:0] sc_ext;
  logic [CW-1:0] n_wide;
  logic [NW-1:0] n_eff;
  logic [CW-1:0] idx_ext;
  logic          in_range;
  logic          accept;

  always_comb begin
    sc_ext = CW'(count_reg);
    if (sc_ext == '0) begin
      n_wide = CW'(1);
    end else if (sc_ext > CW'(MAX_SAMPLES)) begin
      n_wide = CW'(MAX_SAMPLES);
    end else begin
      n_wide = sc_ext;
    end
    n_eff    = n_wide[NW-1:0];
    idx_ext  = CW'(in_item.index);
    in_range = idx_ext < n_wide;
  end

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Memories
  logic          surf_we;
  logic [AW-1:0] surf_waddr;
  logic [AW-1:0] surf_raddr;
  logic [31:0]   surf_rdata;
  logic          sag_we;
  logic [31:0]   sag_wdata;
  logic [31:0]   sag_rdata;

  rbsd_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_surf (
    .clk     (clk),
    .we      (surf_we),
    .wr_addr (surf_waddr),
    .wr_data (in_item.height),
    .rd_addr (surf_raddr),
    .rd_data (surf_rdata)
  );

  rbsd_ram #(.WIDTH(32), .DEPTH(MAX_REACH + 1)) u_sag (
    .clk     (clk),
    .we      (sag_we),
    .wr_addr (k),
    .wr_data (sag_wdata),
    .rd_addr (mag),
    .rd_data (sag_rdata)
  );

  // Shared step logic
  logic [33:0]        div_rs;
  logic               div_ge;
  logic [63:0]        sq_t;
  logic               sq_ge;
  logic [31:0]        mul_a;
  logic signed [33:0] cand;
  logic signed [33:0] best_new;
  logic               q_done;
  logic [NW:0]        nb_start;
  logic [NW:0]        nb_inc;
  logic [31:0]        lim_w;
  logic [31:0]        half_w;
  logic [32:0]        den;

  always_comb begin
    div_rs = {div_r[32:0], div_q[63]};
    div_ge = div_rs >= {1'b0, div_d};
    sq_t   = sq_r + sq_b;
    sq_ge  = sq_v >= sq_t;
    mul_a  = (state == ST_B_RSQ) ? ball_radius : d_val;
    cand   = $signed({{2{surf_rdata[31]}}, surf_rdata}) - $signed({2'b00, sag_rdata});
    best_new = (first || cand > best) ? cand : best;
    q_done = !neg && (mag == reach_reg);
    nb_start = (NW+1)'(idx_ext[NW-1:0]) + (NW+1)'(n_eff) - (NW+1)'(reach_reg);
    if (nb_start >= (NW+1)'(n_eff)) begin
      nb_start = nb_start - (NW+1)'(n_eff);
    end
    nb_inc = (NW+1)'(nb) + (NW+1)'(1);
    half_w = 32'(n_eff >> 1);
    lim_w  = div_q[31:0];
    if (half_w < lim_w) begin
      lim_w = half_w;
    end
    if (32'(MAX_REACH) < lim_w) begin
      lim_w = 32'(MAX_REACH);
    end
    den = {1'b0, ball_radius} + {1'b0, sq_r[31:0]};
    sag_wdata = (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.cmd == CMD_BUILD) begin
            state_next = (sample_spacing != '0) ? ST_DIV : ST_B_LIM;
          end else if (in_item.cmd == CMD_QUERY && table_ready && in_range) begin
            state_next = ST_Q_RD;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (step_cnt == 6'd63) begin
          state_next = div_sag ? ST_B_WR : ST_B_LIM;
        end
      end
      ST_B_LIM:  state_next = ST_B_RSQ;
      ST_B_RSQ:  state_next = ST_B_DSQ;
      ST_B_DSQ:  state_next = ST_B_SQI;
      ST_B_SQI:  state_next = ST_B_SQRT;
      ST_B_SQRT: begin
        if (step_cnt == 6'd31) begin
          state_next = ST_B_DEN;
        end
      end
      ST_B_DEN:  state_next = (den == '0) ? ST_B_WR : ST_DIV;
      ST_B_WR:   state_next = (k == lim) ? ST_OUT : ST_B_DSQ;
      ST_Q_RD:   state_next = ST_Q_EV;
      ST_Q_EV:   state_next = q_done ? ST_OUT : ST_Q_RD;
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    in_stall   = (state != ST_IDLE);
    out_valid  = (state == ST_OUT);
    surf_we    = (state == ST_IDLE) && accept && (in_item.cmd == CMD_WRITE) && in_range;
    surf_waddr = idx_ext[AW-1:0];
    surf_raddr = nb[AW-1:0];
    sag_we     = (state == ST_B_WR);
    out_item.curve_height = curve;
    out_item.reach        = 10'(reach_reg);
    out_item.status       = status;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count_reg      <= 11'd1024;
      ball_radius    <= 32'd65536;
      sample_spacing <= 32'd65536;
      table_ready    <= 1'b0;
      reach_reg      <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SAMPLE_COUNT: begin
            count_reg   <= cfg_data[10:0];
            table_ready <= 1'b0;
          end
          REG_BALL_RADIUS: begin
            ball_radius <= cfg_data;
            table_ready <= 1'b0;
          end
          REG_SAMPLE_SPACING: begin
            sample_spacing <= cfg_data;
            table_ready    <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state == ST_B_LIM) begin
        reach_reg <= lim_w[RW-1:0];
      end
      if (state == ST_B_WR && k == lim) begin
        table_ready <= 1'b1;
      end
    end
  end

  // Datapath: divider, square root, multiplier, query walk
  always_ff @(posedge clk) begin
    prod <= mul_a * d_val;
    unique case (state)
      ST_IDLE: begin
        step_cnt <= '0;
        first    <= 1'b1;
        curve    <= '0;
        div_sag  <= 1'b0;
        div_r    <= '0;
        div_q    <= {32'd0, ball_radius};
        div_d    <= {1'b0, sample_spacing};
        if (in_item.cmd == CMD_BUILD && sample_spacing == '0) begin
          div_q <= '1;
        end
        status <= STAT_OK;
        if (in_item.cmd == CMD_WRITE && !in_range) begin
          status <= STAT_RANGE;
        end else if (in_item.cmd == CMD_QUERY) begin
          if (!table_ready) begin
            status <= STAT_NOT_BUILT;
          end else if (!in_range) begin
            status <= STAT_RANGE;
          end
        end
        nb    <= nb_start[NW-1:0];
        mag   <= reach_reg;
        neg   <= (reach_reg != '0);
      end
      ST_DIV: begin
        step_cnt <= step_cnt + 6'd1;
        if (div_ge) begin
          div_r <= div_rs - {1'b0, div_d};
          div_q <= {div_q[62:0], 1'b1};
        end else begin
          div_r <= div_rs;
          div_q <= {div_q[62:0], 1'b0};
        end
      end
      ST_B_LIM: begin
        lim   <= lim_w[RW-1:0];
        k     <= '0;
        d_val <= ball_radius;
      end
      ST_B_RSQ: begin
        d_val <= '0;
      end
      ST_B_DSQ: begin
        if (k == '0) begin
          r2 <= prod;
        end
      end
      ST_B_SQI: begin
        sq_v     <= (r2 >= prod) ? r2 - prod : '0;
        sq_r     <= '0;
        sq_b     <= 64'd1 << 62;
        step_cnt <= '0;
      end
      ST_B_SQRT: begin
        step_cnt <= step_cnt + 6'd1;
        if (sq_ge) begin
          sq_v <= sq_v - sq_t;
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_b <= sq_b >> 2;
      end
      ST_B_DEN: begin
        step_cnt <= '0;
        div_sag  <= 1'b1;
        div_r    <= '0;
        div_d    <= den;
        div_q    <= (den == '0) ? '0 : prod;
      end
      ST_B_WR: begin
        k     <= k + RW'(1);
        d_val <= d_val + sample_spacing;
      end
      ST_Q_RD: begin
      end
      ST_Q_EV: begin
        first <= 1'b0;
        best  <= best_new;
        if (q_done) begin
          curve <= best_new[31:0];
        end else begin
          nb <= (nb_inc >= (NW+1)'(n_eff)) ? '0 : nb_inc[NW-1:0];
          if (neg) begin
            mag <= mag - RW'(1);
            if (mag == RW'(1)) begin
              neg <= 1'b0;
            end
          end else begin
            mag <= mag + RW'(1);
          end
        end
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule
